>>> hw/rtl/sample_mean_covariance_top_macros.svh
// Assertion macros for the sample mean and covariance block.
`ifndef SAMPLE_MEAN_COVARIANCE_TOP_MACROS_SVH
`define SAMPLE_MEAN_COVARIANCE_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define SMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define SMC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Types, constants and codes shared by the sample mean and covariance block.
// ----------------------------------------------------------------------------
`default_nettype none

package smc_pkg;

	localparam int MAX_VARS    = 8;
	localparam int MAX_OBS     = 1024;
	localparam int VAR_W       = 3;
	localparam int OBS_W       = 10;
	localparam int ADDR_W      = VAR_W + OBS_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int NVARS_W     = 4;
	localparam int NOBS_W      = 11;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 11;
	localparam int SMP_W       = 32;
	localparam int ACC_W       = 80;
	localparam int VAL_W       = 64;
	localparam int DIV_STEPS   = ACC_W;
	localparam int DCNT_W      = 7;

	localparam logic [CFG_IDX_W-1:0] REG_VARS_IN_USE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OBS_IN_USE  = 4'd1;

	localparam logic KIND_MEAN = 1'b0;
	localparam logic KIND_COV  = 1'b1;

	typedef struct packed {
		logic [VAR_W-1:0]        var_index;
		logic [OBS_W-1:0]        obs_index;
		logic signed [SMP_W-1:0] sample;
		logic                    load_done;
	} smc_in_t;

	typedef struct packed {
		logic                    kind;
		logic [VAR_W-1:0]        row_index;
		logic [VAR_W-1:0]        col_index;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} smc_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M_ADDR,
		S_M_ACC,
		S_C_LDI,
		S_C_LDJ,
		S_C_ADDR,
		S_C_DIFF,
		S_C_MUL,
		S_C_ACC,
		S_DLOAD,
		S_DIV,
		S_FIN,
		S_EMIT
	} smc_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/smc_stream_if.sv
// ----------------------------------------------------------------------------
// smc_in_if / smc_out_if
// Valid/ready channels that carry one sample word or one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface smc_in_if;
	import smc_pkg::*;
	logic    valid;
	logic    ready;
	smc_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smc_out_if;
	import smc_pkg::*;
	logic     valid;
	logic     ready;
	smc_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sample_mean_covariance_top.sv
// ----------------------------------------------------------------------------
// sample_mean_covariance_top
// Sample store with per-variable mean and two-pass sample covariance.
// ----------------------------------------------------------------------------
// Usage: samples are written one word per cycle on the samples channel, each
// addressed by variable and observation index. The word with load_done set
// is stored too and starts the run; samples is not ready until the run ends.
// Results leave on the results channel: n means, then the lower triangle of
// the covariance row by row, the last word flagged with last.
// Each mean and each covariance entry comes from the single read-accumulate
// loop over the store followed by the shared bit-serial divider.
// One result word is held at a time; while the receiver stalls, the run
// waits on that word and resumes when it is taken.
// Reset clears the mean registers, the accumulator and the control state,
// and sets vars_in_use to 1 and obs_in_use to 2. The sample store is not
// cleared; every entry must be written before a run reads it.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_mean_covariance_top
	import smc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	smc_in_if.sink                     samples,
	smc_out_if.source                  results
);

	smc_state_t state_q, state_d;

	logic [NVARS_W-1:0] vars_q;
	logic [NOBS_W-1:0]  obs_q;
	logic [NVARS_W-1:0] n_eff;
	logic [NOBS_W-1:0]  m_eff;

	logic signed [SMP_W-1:0] store [STORE_DEPTH];
	logic signed [SMP_W-1:0] rda_q, rdb_q;
	logic [ADDR_W-1:0]       ra, rb, wa;
	logic                    wr;

	logic signed [SMP_W-1:0] mean_regs_q [MAX_VARS];
	logic [VAR_W-1:0]        mean_sel;
	logic signed [SMP_W-1:0] mi_q, mj_q;

	logic [VAR_W-1:0]  i_q, j_q;
	logic [NOBS_W-1:0] k_q;
	logic              cov_q;

	logic signed [ACC_W-1:0] acc_q;
	logic [SMP_W-1:0]        mx_q, my_q;
	logic                    pneg_q;
	logic [2*SMP_W-1:0]      prod_q;

	logic [ACC_W-1:0]  div_q;
	logic [NOBS_W-1:0] rem_q;
	logic [NOBS_W-1:0] dvs_q;
	logic              qneg_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [NOBS_W:0]   rem_next;
	logic              rem_ge;

	logic signed [SMP_W:0] dx, dy;
	logic [ACC_W-1:0]      quo_s;
	logic [VAL_W-1:0]      res_val;

	logic     out_valid_q;
	smc_out_t out_q;

	logic in_acc, out_acc;
	logic k_end, i_end, j_end;

	always_comb begin
		if (vars_q == '0) n_eff = NVARS_W'(1);
		else if (vars_q > NVARS_W'(MAX_VARS)) n_eff = NVARS_W'(MAX_VARS);
		else n_eff = vars_q;
		if (obs_q < NOBS_W'(2)) m_eff = NOBS_W'(2);
		else if (obs_q > NOBS_W'(MAX_OBS)) m_eff = NOBS_W'(MAX_OBS);
		else m_eff = obs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vars_q <= NVARS_W'(1);
			obs_q  <= NOBS_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VARS_IN_USE: vars_q <= cfg_data[NVARS_W-1:0];
				REG_OBS_IN_USE:  obs_q  <= cfg_data[NOBS_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_acc  = samples.valid && samples.ready;
	assign out_acc = results.valid && results.ready;
	assign k_end   = (k_q == m_eff - NOBS_W'(1));
	assign i_end   = (NVARS_W'(i_q) == n_eff - NVARS_W'(1));
	assign j_end   = (j_q == i_q);

	// Sample store: one write port, two registered read ports.
	assign wa = {samples.data.var_index, samples.data.obs_index};
	assign wr = in_acc && (int'(samples.data.var_index) < MAX_VARS)
		&& (int'(samples.data.obs_index) < MAX_OBS);
	assign ra = {i_q, k_q[OBS_W-1:0]};
	assign rb = {j_q, k_q[OBS_W-1:0]};

	always_ff @(posedge clk) begin
		if (wr) store[wa] <= samples.data.sample;
		rda_q <= store[ra];
		rdb_q <= store[rb];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_acc && samples.data.load_done) state_d = S_M_ADDR;
			S_M_ADDR: state_d = S_M_ACC;
			S_M_ACC:  state_d = k_end ? S_DLOAD : S_M_ADDR;
			S_C_LDI:  state_d = S_C_LDJ;
			S_C_LDJ:  state_d = S_C_ADDR;
			S_C_ADDR: state_d = S_C_DIFF;
			S_C_DIFF: state_d = S_C_MUL;
			S_C_MUL:  state_d = S_C_ACC;
			S_C_ACC:  state_d = k_end ? S_DLOAD : S_C_ADDR;
			S_DLOAD:  state_d = S_DIV;
			S_DIV:    if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) state_d = S_FIN;
			S_FIN:    state_d = S_EMIT;
			S_EMIT: begin
				if (out_acc) begin
					if (!cov_q) state_d = i_end ? S_C_LDI : S_M_ADDR;
					else if (j_end && i_end) state_d = S_IDLE;
					else state_d = S_C_LDI;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		samples.ready = (state_q == S_IDLE);
		results.valid = out_valid_q;
		results.data  = out_q;
		mean_sel      = (state_q == S_C_LDI) ? i_q : j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Deviations and the divider step.
	assign dx       = {rda_q[SMP_W-1], rda_q} - {mi_q[SMP_W-1], mi_q};
	assign dy       = {rdb_q[SMP_W-1], rdb_q} - {mj_q[SMP_W-1], mj_q};
	assign rem_next = {rem_q, div_q[ACC_W-1]};
	assign rem_ge   = (rem_next >= {1'b0, dvs_q});
	assign quo_s    = qneg_q ? (~div_q + ACC_W'(1)) : div_q;

	always_comb begin
		if (qneg_q) begin
			if (div_q[ACC_W-1:VAL_W] != '0 || div_q[VAL_W-1:0] > {1'b1, {(VAL_W-1){1'b0}}})
				res_val = {1'b1, {(VAL_W-1){1'b0}}};
			else
				res_val = ~div_q[VAL_W-1:0] + VAL_W'(1);
		end else begin
			if (div_q[ACC_W-1:VAL_W-1] != '0) res_val = {1'b0, {(VAL_W-1){1'b1}}};
			else res_val = div_q[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			cov_q       <= 1'b0;
			acc_q       <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			for (int v = 0; v < MAX_VARS; v++) mean_regs_q[v] <= '0;
		end else begin
			if (out_acc) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					i_q   <= '0;
					j_q   <= '0;
					k_q   <= '0;
					cov_q <= 1'b0;
					acc_q <= '0;
				end
				S_M_ACC: begin
					acc_q <= acc_q + ACC_W'(rda_q);
					k_q   <= k_q + NOBS_W'(1);
				end
				S_C_LDI: begin
					mi_q  <= mean_regs_q[mean_sel];
					acc_q <= '0;
					k_q   <= '0;
				end
				S_C_LDJ: mj_q <= mean_regs_q[mean_sel];
				S_C_DIFF: begin
					mx_q   <= dx[SMP_W] ? SMP_W'(-dx) : dx[SMP_W-1:0];
					my_q   <= dy[SMP_W] ? SMP_W'(-dy) : dy[SMP_W-1:0];
					pneg_q <= dx[SMP_W] ^ dy[SMP_W];
				end
				S_C_MUL: prod_q <= mx_q * my_q;
				S_C_ACC: begin
					if (pneg_q) acc_q <= acc_q - $signed({16'b0, prod_q});
					else acc_q <= acc_q + $signed({16'b0, prod_q});
					k_q <= k_q + NOBS_W'(1);
				end
				S_DLOAD: begin
					qneg_q <= acc_q[ACC_W-1];
					div_q  <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
					rem_q  <= '0;
					dvs_q  <= cov_q ? (m_eff - NOBS_W'(1)) : m_eff;
					dcnt_q <= '0;
				end
				S_DIV: begin
					rem_q  <= rem_ge ? NOBS_W'(rem_next - {1'b0, dvs_q}) : rem_next[NOBS_W-1:0];
					div_q  <= {div_q[ACC_W-2:0], rem_ge};
					dcnt_q <= dcnt_q + DCNT_W'(1);
				end
				S_FIN: begin
					out_valid_q     <= 1'b1;
					out_q.row_index <= i_q;
					if (!cov_q) begin
						mean_regs_q[i_q] <= quo_s[SMP_W-1:0];
						out_q.kind       <= KIND_MEAN;
						out_q.col_index  <= i_q;
						out_q.value      <= VAL_W'($signed(quo_s[SMP_W-1:0]));
						out_q.last       <= 1'b0;
					end else begin
						out_q.kind      <= KIND_COV;
						out_q.col_index <= j_q;
						out_q.value     <= res_val;
						out_q.last      <= i_end && j_end;
					end
				end
				S_EMIT: begin
					if (out_acc) begin
						acc_q <= '0;
						k_q   <= '0;
						if (!cov_q) begin
							if (i_end) begin
								cov_q <= 1'b1;
								i_q   <= '0;
								j_q   <= '0;
							end else begin
								i_q <= i_q + VAR_W'(1);
							end
						end else if (j_end) begin
							i_q <= i_q + VAR_W'(1);
							j_q <= '0;
						end else begin
							j_q <= j_q + VAR_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

`include "sample_mean_covariance_top_macros.svh"

	`SMC_ASSERT(a_no_load_while_result, samples.ready |-> !results.valid, "ready with result pending")
	`SMC_ASSERT(a_mean_not_last, (results.valid && results.data.kind == KIND_MEAN) |-> !results.data.last, "mean word flagged last")
	`SMC_ASSERT(a_div_bound, (state_q == S_DIV) |-> (dcnt_q < DCNT_W'(DIV_STEPS)), "divider overran")
	`SMC_ASSERT(a_last_ends_run, (out_acc && results.data.last) |=> (state_q == S_IDLE), "run did not end after last word")

endmodule

`default_nettype wire
